// ===== hw/rtl/mmde_pkg.sv =====
// ----------------------------------------------------------------------------
// mmde_pkg: shared types and constants for the matrix dot engine
// Field widths, register indexes and the tag that travels with each request.
// ----------------------------------------------------------------------------
`default_nettype none

package mmde_pkg;

    // element and result widths
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = 48;
    localparam int IDX_W       = 12;
    localparam int FIELD_LANES = 4;

    // stream widths
    localparam int IN_TDATA_W  = 2 * FIELD_LANES * ELEM_W;
    localparam int OUT_TDATA_W = ACC_W + 2 * IDX_W;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_INNER_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COLUMNS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS     = 2'd2;

    // parameter defaults
    localparam int DEFAULT_LANES   = 4;
    localparam int DEFAULT_MAX_DIM = 4096;

    // per-request control that follows the data down the pipeline
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mmde_lane.sv =====
// ----------------------------------------------------------------------------
// mmde_lane: one multiply lane
// Registers the signed product of one element pair, or zero for an unused lane.
// ----------------------------------------------------------------------------
`default_nettype none

module mmde_lane (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic                                use_lane,
    input  wire logic signed [mmde_pkg::ELEM_W-1:0]  a,
    input  wire logic signed [mmde_pkg::ELEM_W-1:0]  b,
    output logic signed      [mmde_pkg::PROD_W-1:0]  prod_reg
);
    import mmde_pkg::*;

    logic signed [PROD_W-1:0] prod_next;

    // drop the product of a lane past the inner length
    assign prod_next = use_lane ? PROD_W'(a) * PROD_W'(b) : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mmde_merge.sv =====
// ----------------------------------------------------------------------------
// mmde_merge: lane merge and accumulator
// Sums the lane products in a registered tree, adds them into the running
// accumulator and loads finished dot products into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmde_merge #(
    parameter int LANES = mmde_pkg::DEFAULT_LANES
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire mmde_pkg::tag_t                      in_tag,
    input  wire logic signed [mmde_pkg::PROD_W-1:0]  prod [LANES],
    output logic                                     out_valid_reg,
    input  wire logic                                out_ready,
    output logic signed      [mmde_pkg::ACC_W-1:0]   out_sum_reg,
    output mmde_pkg::tag_t                           out_tag_reg
);
    import mmde_pkg::*;

    localparam int SUM_W = PROD_W + $clog2(LANES);

    logic                    v2_reg;
    tag_t                    tag2_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] total;
    logic                    adv;

    // add the lane products
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < LANES; i++) begin
            sum_next = sum_next + SUM_W'(prod[i]);
        end
    end

    // a finishing request waits only for a free output register
    assign adv      = !v2_reg || !tag2_reg.done || !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign total    = acc_reg + ACC_W'(sum_reg);

    // tree stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            sum_reg  <= sum_next;
            tag2_reg <= in_tag;
        end
    end

    // accumulate, clear after each finished cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (v2_reg && adv) begin
            acc_reg <= tag2_reg.done ? '0 : total;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (v2_reg && adv && tag2_reg.done) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && adv && tag2_reg.done) begin
            out_sum_reg <= total;
            out_tag_reg <= tag2_reg;
        end
    end

`ifndef SYNTHESIS
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && adv && tag2_reg.done) |=> (acc_reg == '0))
        else $error("accumulator not cleared after finished cell");

    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready && v2_reg && tag2_reg.done) |-> !in_ready)
        else $error("finished cell advanced into a full output register");

    a_load_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(v2_reg && tag2_reg.done))
        else $error("output loaded without a finishing request");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_multiply_dot_engine_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_dot_engine_unit: dot-product engine for C = A * B^T
// Takes LANES Q8.8 element pairs per request, multiplies them in parallel
// lanes, merges and accumulates them and emits one Q32.16 cell with its index.
// ----------------------------------------------------------------------------
// A cell's last request passes the multiply, tree and output registers.
// Throughput: one request per cycle unless the output stalls; set by the
// single accumulator add stage. A finished cell waits in the output register
// while requests keep flowing until a second finished cell reaches the
// accumulator stage. Reset (aresetn low, synchronous): pipeline empty,
// counters and accumulator zero, all three registers read 1.
`default_nettype none

module matrix_multiply_dot_engine_unit #(
    parameter int LANES   = mmde_pkg::DEFAULT_LANES,
    parameter int MAX_DIM = mmde_pkg::DEFAULT_MAX_DIM
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration
    input  wire logic                                 cfg_we,
    input  wire logic [mmde_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mmde_pkg::CFG_W-1:0]           cfg_wdata,
    // input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // a_lane0, a_lane1, a_lane2, a_lane3, b_lane0, b_lane1, b_lane2, b_lane3
    input  wire logic [mmde_pkg::IN_TDATA_W-1:0]      s_tdata,
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // dot_sum, row_index, col_index
    output logic [mmde_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic                                      m_tlast
);
    import mmde_pkg::*;

    localparam int DIM_CAP = (MAX_DIM < 8191) ? MAX_DIM : 8191;
    localparam int CNT_W   = $clog2(DIM_CAP);
    localparam int LCNT_W  = $clog2(LANES + 1);

    logic [CFG_W-1:0]  inner_reg, cols_reg, rows_reg;
    logic [CFG_W-1:0]  inner_eff, cols_eff, rows_eff;
    logic [CFG_W-1:0]  pair_cnt_reg;
    logic [CNT_W-1:0]  cur_row_reg, cur_col_reg;
    logic [CFG_W:0]    new_pair;
    logic [LCNT_W-1:0] taken;
    logic [LANES-1:0]  use_lane;
    logic              accept, done, col_last, row_last;
    logic [31:0]       row_w, col_w;
    tag_t              tag_next, tag1_reg, out_tag;
    logic              v1_reg, merge_ready;
    logic signed [PROD_W-1:0] prod [LANES];
    logic signed [ACC_W-1:0]  out_sum;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_reg <= CFG_W'(1);
            cols_reg  <= CFG_W'(1);
            rows_reg  <= CFG_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_INNER_LENGTH: inner_reg <= cfg_wdata;
                REG_OUT_COLUMNS:  cols_reg  <= cfg_wdata;
                REG_OUT_ROWS:     rows_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp the limits
    assign inner_eff = (inner_reg == '0) ? CFG_W'(1) : inner_reg;
    assign cols_eff  = (cols_reg == '0) ? CFG_W'(1) :
                       (cols_reg > CFG_W'(DIM_CAP)) ? CFG_W'(DIM_CAP) : cols_reg;
    assign rows_eff  = (rows_reg == '0) ? CFG_W'(1) :
                       (rows_reg > CFG_W'(DIM_CAP)) ? CFG_W'(DIM_CAP) : rows_reg;

    assign s_tready = !v1_reg || merge_ready;
    assign accept   = s_tvalid && s_tready;

    // mark the lanes inside the inner length and count them
    always_comb begin
        taken = '0;
        for (int i = 0; i < LANES; i++) begin
            use_lane[i] = ((CFG_W + 1)'(pair_cnt_reg) + (CFG_W + 1)'(i))
                          < (CFG_W + 1)'(inner_eff);
            taken = taken + LCNT_W'(use_lane[i]);
        end
    end

    assign new_pair = (CFG_W + 1)'(pair_cnt_reg) + (CFG_W + 1)'(taken);
    assign done     = new_pair >= (CFG_W + 1)'(inner_eff);
    assign col_last = ((CFG_W + 1)'(cur_col_reg) + 1'b1) >= (CFG_W + 1)'(cols_eff);
    assign row_last = ((CFG_W + 1)'(cur_row_reg) + 1'b1) >= (CFG_W + 1)'(rows_eff);
    assign row_w    = 32'(cur_row_reg);
    assign col_w    = 32'(cur_col_reg);

    always_comb begin
        tag_next.done = done;
        tag_next.row  = row_w[IDX_W-1:0];
        tag_next.col  = col_w[IDX_W-1:0];
        tag_next.last = row_last && col_last;
    end

    // pair and cell counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_cnt_reg <= '0;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
        end else if (accept) begin
            if (done) begin
                pair_cnt_reg <= '0;
                if (col_last) begin
                    cur_col_reg <= '0;
                    cur_row_reg <= row_last ? '0 : CNT_W'(cur_row_reg + 1'b1);
                end else begin
                    cur_col_reg <= CNT_W'(cur_col_reg + 1'b1);
                end
            end else begin
                pair_cnt_reg <= new_pair[CFG_W-1:0];
            end
        end
    end

    // multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_tready) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tag1_reg <= tag_next;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mmde_lane u_lane (
            .aclk     (aclk),
            .en       (accept),
            .use_lane (use_lane[g]),
            .a        (s_tdata[g*ELEM_W +: ELEM_W]),
            .b        (s_tdata[(FIELD_LANES + g)*ELEM_W +: ELEM_W]),
            .prod_reg (prod[g])
        );
    end

    mmde_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (v1_reg),
        .in_ready      (merge_ready),
        .in_tag        (tag1_reg),
        .prod          (prod),
        .out_valid_reg (m_tvalid),
        .out_ready     (m_tready),
        .out_sum_reg   (out_sum),
        .out_tag_reg   (out_tag)
    );

    assign m_tdata = {out_tag.col, out_tag.row, out_sum};
    assign m_tlast = out_tag.last;

`ifndef SYNTHESIS
    a_pair_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && done) |=> (pair_cnt_reg == '0))
        else $error("pair count not cleared after finished cell");

    a_pair_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !done) |=> (pair_cnt_reg != '0))
        else $error("pair count empty after partial request");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !merge_ready) |=> (v1_reg && $stable(tag1_reg)))
        else $error("multiply stage lost a stalled request");
`endif

endmodule

`default_nettype wire

// ===== tb/mmde_cell_checker.sv =====
// ----------------------------------------------------------------------------
// mmde_cell_checker: expected-cell tracker for the matrix dot engine
// Watches the configuration port and both streams, rebuilds every finished
// dot product from the accepted requests, and compares each delivered cell
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module mmde_cell_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [mmde_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mmde_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // a_lane0..a_lane3, b_lane0..b_lane3
    input  logic [mmde_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // dot_sum, row_index, col_index
    input  logic [mmde_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             m_tlast,
    output int                               mismatches,
    output int                               cells_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mmde_pkg::*;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    done;
    } cell_t;

    cell_t expected_cells[$];

    // shadow registers and cell state
    logic [CFG_W-1:0]        inner_reg;
    logic [CFG_W-1:0]        cols_reg;
    logic [CFG_W-1:0]        rows_reg;
    int                      pairs_taken;
    logic signed [ACC_W-1:0] dot_acc;
    int                      row_q;
    int                      col_q;

    // zero acts as one, anything above the maximum saturates
    function automatic int dim_limit(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > DEFAULT_MAX_DIM) return DEFAULT_MAX_DIM;
        return int'(v);
    endfunction

    always @(posedge aclk) begin : watch
        cell_t                    got;
        cell_t                    want;
        int                       inner_eff;
        int                       cols_eff;
        int                       rows_eff;
        int                       taken;
        logic signed [ELEM_W-1:0] a_elem;
        logic signed [ELEM_W-1:0] b_elem;

        if (!aresetn) begin
            inner_reg   = 1;
            cols_reg    = 1;
            rows_reg    = 1;
            pairs_taken = 0;
            dot_acc     = '0;
            row_q       = 0;
            col_q       = 0;
            expected_cells.delete();
        end else begin
            // compare a delivered cell with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.sum  = m_tdata[ACC_W-1:0];
                got.row  = m_tdata[ACC_W +: IDX_W];
                got.col  = m_tdata[ACC_W+IDX_W +: IDX_W];
                got.done = m_tlast;
                if (expected_cells.size() == 0) begin
                    $display("%0t: unexpected cell, actual sum %0d row %0d col %0d last %0b",
                             $time, got.sum, got.row, got.col, got.done);
                    mismatches++;
                end else begin
                    want = expected_cells.pop_front();
                    if (got.sum !== want.sum) begin
                        $display("%0t: dot_sum expected %0d actual %0d",
                                 $time, want.sum, got.sum);
                        mismatches++;
                    end
                    if (got.row !== want.row) begin
                        $display("%0t: row_index expected %0d actual %0d",
                                 $time, want.row, got.row);
                        mismatches++;
                    end
                    if (got.col !== want.col) begin
                        $display("%0t: col_index expected %0d actual %0d",
                                 $time, want.col, got.col);
                        mismatches++;
                    end
                    if (got.done !== want.done) begin
                        $display("%0t: matrix_done expected %0b actual %0b",
                                 $time, want.done, got.done);
                        mismatches++;
                    end
                end
            end

            // track register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_INNER_LENGTH: inner_reg = cfg_wdata;
                    REG_OUT_COLUMNS:  cols_reg  = cfg_wdata;
                    REG_OUT_ROWS:     rows_reg  = cfg_wdata;
                    default: ;
                endcase
            end

            // accumulate the live lanes of an accepted request
            if (s_tvalid && s_tready) begin
                inner_eff = (inner_reg == 0) ? 1 : int'(inner_reg);
                cols_eff  = dim_limit(cols_reg);
                rows_eff  = dim_limit(rows_reg);
                taken     = 0;
                for (int i = 0; i < DEFAULT_LANES && i < FIELD_LANES; i++) begin
                    if (pairs_taken + i < inner_eff) begin
                        a_elem  = s_tdata[ELEM_W*i +: ELEM_W];
                        b_elem  = s_tdata[ELEM_W*(FIELD_LANES+i) +: ELEM_W];
                        dot_acc = dot_acc + a_elem * b_elem;
                        taken++;
                    end
                end
                pairs_taken += taken;

                // close the cell and advance in row-major order
                if (pairs_taken >= inner_eff) begin
                    want.sum  = dot_acc;
                    want.row  = row_q[IDX_W-1:0];
                    want.col  = col_q[IDX_W-1:0];
                    want.done = (row_q + 1 >= rows_eff) && (col_q + 1 >= cols_eff);
                    expected_cells.push_back(want);
                    dot_acc     = '0;
                    pairs_taken = 0;
                    if (col_q + 1 >= cols_eff) begin
                        col_q = 0;
                        row_q = (row_q + 1 >= rows_eff) ? 0 : row_q + 1;
                    end else begin
                        col_q++;
                    end
                end
            end
        end
        cells_outstanding = expected_cells.size();
    end

endmodule

// ===== tb/tb_matrix_multiply_dot_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_matrix_multiply_dot_engine_unit: stream test of the matrix dot engine
// Drives directed and random rows of A and B through several matrix shapes,
// with random gaps and stalls on both streams, one long output hold-off and
// register changes between phases; the checker predicts every cell.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_dot_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mmde_pkg::*;

    localparam int ITEM_TARGET     = 1650;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 250;

    typedef logic [FIELD_LANES-1:0][ELEM_W-1:0] lane_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int mismatches;
    int cells_outstanding;
    int items_sent   = 0;
    int hold_off_len = 0;
    bit no_idle      = 1'b0;

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    matrix_multiply_dot_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    mmde_cell_checker cell_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .mismatches        (mismatches),
        .cells_outstanding (cells_outstanding)
    );

    // mostly short gaps, a few long ones, none while no_idle is set
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // bias elements toward the signed extremes
    function automatic lane_row_t rand_row();
        lane_row_t row;
        for (int i = 0; i < FIELD_LANES; i++) begin
            case ($urandom_range(0, 9))
                0:       row[i] = 16'h8000;
                1:       row[i] = 16'h7FFF;
                2:       row[i] = 16'h0000;
                3:       row[i] = 16'hFFFF;
                default: row[i] = 16'($urandom);
            endcase
        end
        return row;
    endfunction

    function automatic int pick_inner();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0) return 0;
        if (r == 1) return 8191;
        if (r < 6) return $urandom_range(13, 64);
        return $urandom_range(1, 12);
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 0;
        if (r == 1) return 8191;
        if (r == 2) return $urandom_range(6, 4096);
        return $urandom_range(1, 5);
    endfunction

    // offer one request after a random gap and hold it until accepted
    task automatic push_pairs(input lane_row_t a_row, input lane_row_t b_row);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b_row, a_row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // drop valid, wait for every predicted cell, then let the pipeline settle
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (cells_outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_shape(input int inner, input int cols, input int rows);
        wait_idle();
        write_reg(REG_INNER_LENGTH, inner);
        write_reg(REG_OUT_COLUMNS, cols);
        write_reg(REG_OUT_ROWS, rows);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_len) @(negedge aclk);
                hold_off_len = 0;
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_tready   <= 1'b0;
                stall_left = pick_gap();
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        lane_row_t a_row;
        lane_row_t b_row;
        int        phase;
        int        n_items;
        int        inner_val;
        int        cols_val;
        int        rows_val;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_INNER_LENGTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // signed extremes under the reset shape: one pair per single-cell matrix
        push_pairs({4{16'h8000}}, {4{16'h8000}});
        push_pairs({4{16'h7FFF}}, {4{16'h8000}});
        push_pairs({4{16'h7FFF}}, {4{16'h7FFF}});
        push_pairs('0, '0);

        // zero inner length and zero dimensions act as one
        set_shape(0, 0, 0);
        repeat (2) push_pairs(rand_row(), rand_row());

        // 2x2 matrix of six pairs: the closing request of each cell carries
        // two dead lanes loaded with extremes
        set_shape(6, 2, 2);
        repeat (4) begin
            push_pairs(rand_row(), rand_row());
            a_row    = rand_row();
            b_row    = rand_row();
            a_row[2] = 16'h8000;
            a_row[3] = 16'h7FFF;
            b_row[2] = 16'h8000;
            b_row[3] = 16'h8000;
            push_pairs(a_row, b_row);
        end

        // longest inner length with saturated dimensions: build a partial sum
        set_shape(8191, 8191, 8191);
        repeat (6) push_pairs({4{16'h8000}}, {4{16'h8000}});

        // shrink the inner length mid-cell: the next request closes the cell
        wait_idle();
        write_reg(REG_INNER_LENGTH, 2);
        repeat (3) push_pairs(rand_row(), rand_row());

        // random phases with state kept, each rewriting part or all of the shape
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            inner_val = pick_inner();
            cols_val  = pick_dim();
            rows_val  = pick_dim();
            if (phase == 3) begin
                inner_val = 1;
                cols_val  = 3;
                rows_val  = 2;
            end
            wait_idle();
            if (phase <= 3 || $urandom_range(0, 3) != 0)
                write_reg(REG_INNER_LENGTH, inner_val);
            if (phase <= 3 || $urandom_range(0, 3) != 0)
                write_reg(REG_OUT_COLUMNS, cols_val);
            if (phase <= 3 || $urandom_range(0, 3) != 0)
                write_reg(REG_OUT_ROWS, rows_val);
            // hold the result side while requests keep coming
            if (phase == 3) hold_off_len = HOLD_OFF_CYCLES;
            no_idle = ($urandom_range(0, 4) == 0);
            n_items = $urandom_range(20, 80);
            repeat (n_items) push_pairs(rand_row(), rand_row());
            no_idle = 1'b0;
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
